// ===== sv/piae_pkg.sv =====
// piae_pkg: shared types, constants and helpers for the priority interrupt
// controller with acknowledge and end-of-interrupt
// no dependencies

package piae_pkg;

   // line count and field widths
   localparam int NUM_LINES  = 8;
   localparam int LINE_SLOTS = 8;
   localparam int LINE_W     = 3;
   localparam int VEC_W      = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;
   localparam int CFG_COUNT  = 8;

   localparam logic [LINE_SLOTS-1:0] ACTIVE_MASK =
      (NUM_LINES >= LINE_SLOTS) ? {LINE_SLOTS{1'b1}}
                                : LINE_SLOTS'((64'd1 << NUM_LINES) - 64'd1);

   typedef enum logic [1:0] {
      REQ_RAISE    = 2'd0,
      REQ_WITHDRAW = 2'd1,
      REQ_ACK      = 2'd2,
      REQ_EOI      = 2'd3
   } req_code_type;

   typedef struct packed {
      logic [VEC_W-1:0]      vector;
      logic                  vector_valid;
      logic [LINE_W-1:0]     served_line;
      logic                  eoi_done;
      logic [LINE_SLOTS-1:0] pending_now;
      logic [LINE_SLOTS-1:0] in_service_now;
   } rsp_word_type;

   // index of the lowest set bit, zero when none is set
   function automatic logic [LINE_W-1:0] lowest_bit(input logic [LINE_SLOTS-1:0] v);
      logic [LINE_W-1:0] idx;
      idx = '0;
      for (int i = LINE_SLOTS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = LINE_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== sv/priority_interrupt_ack_eoi_top.sv =====
// priority_interrupt_ack_eoi_top: eight-line priority interrupt controller
// with acknowledge and end-of-interrupt, one request word in, one status word out
// depends on piae_pkg
//
// usage
// - request channel (req_valid / req_stall): each word raises or withdraws a
//   pending line, acknowledges the highest priority line (lowest number) that is
//   pending and not in service, or ends the lowest numbered in-service line
// - response channel (rsp_valid / rsp_stall): exactly one word per request, in
//   order, carrying the acknowledged vector, the served line, the eoi flag and
//   the pending / in-service bits after the request
// - csr port: csr_we writes csr_wdata into vector register csr_index (0..7),
//   higher indexes are dropped; write only while no request is in flight
// timing
// - response: a request accepted at an edge is offered on the response port right
//   after that edge, or parked in the skid register while the receiver stalls
// - throughput: one request per cycle while req_stall is low; the state update
//   is a single priority encode and mask update done in the accept cycle
// - stall: a two-deep output (response register plus skid register) keeps the
//   request side open for one more word while the receiver stalls; req_stall
//   rises only when the skid register is occupied
// - reset: synchronous, clears pending / in-service bits, vector registers and
//   both output slots

module priority_interrupt_ack_eoi_top (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_type,
   input  logic [piae_pkg::LINE_W-1:0]         req_line,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [piae_pkg::VEC_W-1:0]          rsp_vector,
   output logic                                rsp_vector_valid,
   output logic [piae_pkg::LINE_W-1:0]         rsp_served_line,
   output logic                                rsp_eoi_done,
   output logic [piae_pkg::LINE_SLOTS-1:0]     rsp_pending_now,
   output logic [piae_pkg::LINE_SLOTS-1:0]     rsp_in_service_now,
   // configuration port
   input  logic                                csr_we,
   input  logic [piae_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [piae_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // vector registers, one per line
   logic [piae_pkg::VEC_W-1:0] vec_ff [piae_pkg::CFG_COUNT];

   // controller state
   logic [piae_pkg::LINE_SLOTS-1:0] pending_ff, pending_in;
   logic [piae_pkg::LINE_SLOTS-1:0] in_service_ff, in_service_in;

   // output register and skid register
   logic                    out_valid_ff;
   piae_pkg::rsp_word_type  out_word_ff;
   logic                    skid_valid_ff;
   piae_pkg::rsp_word_type  skid_word_ff;

   logic                    accept;
   piae_pkg::rsp_word_type  new_word;
   piae_pkg::req_code_type  code;
   logic [piae_pkg::LINE_SLOTS-1:0] line_bit;
   logic [piae_pkg::LINE_SLOTS-1:0] ack_cand;
   logic [piae_pkg::LINE_W-1:0]     ack_line;
   logic [piae_pkg::LINE_W-1:0]     eoi_line;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;

   assign code     = piae_pkg::req_code_type'(req_type);
   assign line_bit = piae_pkg::LINE_SLOTS'(1) << req_line;
   assign ack_cand = pending_ff & ~in_service_ff & piae_pkg::ACTIVE_MASK;
   assign ack_line = piae_pkg::lowest_bit(ack_cand);
   assign eoi_line = piae_pkg::lowest_bit(in_service_ff);

   // next state and response word for the request on the port
   always_comb begin
      pending_in    = pending_ff;
      in_service_in = in_service_ff;
      new_word      = '0;
      unique case (code)
         piae_pkg::REQ_RAISE: begin
            pending_in = pending_ff | (line_bit & piae_pkg::ACTIVE_MASK);
         end
         piae_pkg::REQ_WITHDRAW: begin
            pending_in = pending_ff & ~(line_bit & piae_pkg::ACTIVE_MASK);
         end
         piae_pkg::REQ_ACK: begin
            if (ack_cand != '0) begin
               pending_in[ack_line]    = 1'b0;
               in_service_in[ack_line] = 1'b1;
               new_word.vector         = vec_ff[ack_line];
               new_word.vector_valid   = 1'b1;
               new_word.served_line    = ack_line;
            end
         end
         piae_pkg::REQ_EOI: begin
            if (in_service_ff != '0) begin
               in_service_in[eoi_line] = 1'b0;
               new_word.eoi_done       = 1'b1;
               new_word.served_line    = eoi_line;
            end
         end
         default: begin
            pending_in = pending_ff;
         end
      endcase
      new_word.pending_now    = pending_in;
      new_word.in_service_now = in_service_in;
   end

   // vector registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < piae_pkg::CFG_COUNT; i++) begin
            vec_ff[i] <= '0;
         end
      end else if (csr_we && (csr_index < piae_pkg::CSR_IDX_W'(piae_pkg::CFG_COUNT))) begin
         vec_ff[csr_index[piae_pkg::LINE_W-1:0]] <= csr_wdata;
      end
   end

   // line state, updated on every accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         in_service_ff <= '0;
      end else if (accept) begin
         pending_ff    <= pending_in;
         in_service_ff <= in_service_in;
      end
   end

   // output register with skid behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || !rsp_stall) begin
         // output slot is free or drains this cycle
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         // receiver stalled, park the new word
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_word_ff <= skid_word_ff;
         end else if (accept) begin
            out_word_ff <= new_word;
         end
      end else if (accept) begin
         skid_word_ff <= new_word;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_vector         = out_word_ff.vector;
   assign rsp_vector_valid   = out_word_ff.vector_valid;
   assign rsp_served_line    = out_word_ff.served_line;
   assign rsp_eoi_done       = out_word_ff.eoi_done;
   assign rsp_pending_now    = out_word_ff.pending_now;
   assign rsp_in_service_now = out_word_ff.in_service_now;

`ifndef NO_ASSERTIONS
   // skid slot only fills behind a full output slot
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a word while output slot is empty");

   // an acknowledged line is in service and no longer pending
   a_ack_marks_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_vector_valid) |->
         (rsp_in_service_now[rsp_served_line] && !rsp_pending_now[rsp_served_line]))
      else $error("acknowledged line not moved to in service");

   // an ended line has its in-service bit cleared
   a_eoi_clears_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_eoi_done) |-> !rsp_in_service_now[rsp_served_line])
      else $error("ended line still in service");

   // a word never both acknowledges and ends
   a_ack_eoi_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_vector_valid && rsp_eoi_done))
      else $error("response flags both acknowledge and end of interrupt");

   // lines beyond the active count never become pending or in service
   a_inactive_lines_idle: assert property (@(posedge clock) disable iff (reset)
      ((pending_ff | in_service_ff) & ~piae_pkg::ACTIVE_MASK) == '0)
      else $error("inactive line has state bits set");
`endif

endmodule

// ===== test/testbench.sv =====
// testbench for priority_interrupt_ack_eoi_top: random and directed requests
// checked word by word against an in-bench model of the pending / in-service lines
// depends on piae_pkg and the top level rtl

module testbench;

   // request word as the sender queues it
   typedef struct packed {
      piae_pkg::req_code_type      kind;
      logic [piae_pkg::LINE_W-1:0] line;
   } irq_request_type;

   // ways to load the eight vector registers
   typedef enum int {
      VEC_ALL_ZERO,
      VEC_ALL_ONES,
      VEC_ALTERNATE,
      VEC_RANDOM
   } vec_style_type;

   localparam int LONG_HOLD    = 400;    // receiver hold-off used to back the block up
   localparam int BURST_MAX    = 13;     // longest idle burst on either side
   localparam int DRAIN_CYCLES = 40000;  // bound on waiting for outstanding words
   localparam int SETTLE       = 4;      // extra wait after the queues drain, as margin

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [1:0]                          req_type  = '0;
   logic [piae_pkg::LINE_W-1:0]         req_line  = '0;

   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [piae_pkg::VEC_W-1:0]          rsp_vector;
   logic                                rsp_vector_valid;
   logic [piae_pkg::LINE_W-1:0]         rsp_served_line;
   logic                                rsp_eoi_done;
   logic [piae_pkg::LINE_SLOTS-1:0]     rsp_pending_now;
   logic [piae_pkg::LINE_SLOTS-1:0]     rsp_in_service_now;

   logic                                csr_we    = 1'b0;
   logic [piae_pkg::CSR_IDX_W-1:0]      csr_index = '0;
   logic [piae_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;

   priority_interrupt_ack_eoi_top DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_line           (req_line),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_vector         (rsp_vector),
      .rsp_vector_valid   (rsp_vector_valid),
      .rsp_served_line    (rsp_served_line),
      .rsp_eoi_done       (rsp_eoi_done),
      .rsp_pending_now    (rsp_pending_now),
      .rsp_in_service_now (rsp_in_service_now),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // interrupt controller model: own copy of lines and vector registers
   // ---------------------------------------------------------------------
   logic [piae_pkg::LINE_SLOTS-1:0] pending_model = '0;
   logic [piae_pkg::LINE_SLOTS-1:0] service_model = '0;
   logic [piae_pkg::VEC_W-1:0]      vector_table [piae_pkg::CFG_COUNT];

   // apply one request to the model and return the status word it yields
   function automatic piae_pkg::rsp_word_type resolve_request(
         piae_pkg::req_code_type kind, logic [piae_pkg::LINE_W-1:0] ln);
      piae_pkg::rsp_word_type          word;
      logic [piae_pkg::LINE_SLOTS-1:0] line_bit;
      logic [piae_pkg::LINE_SLOTS-1:0] cand;
      int                              hit;
      word     = '0;
      line_bit = piae_pkg::LINE_SLOTS'(1) << ln;
      hit      = -1;
      case (kind)
         piae_pkg::REQ_RAISE: begin
            // raising a line that is already pending or in service just sets it again
            if ((line_bit & piae_pkg::ACTIVE_MASK) != '0) begin
               pending_model = pending_model | line_bit;
            end
         end
         piae_pkg::REQ_WITHDRAW: begin
            if ((line_bit & piae_pkg::ACTIVE_MASK) != '0) begin
               pending_model = pending_model & ~line_bit;
            end
         end
         piae_pkg::REQ_ACK: begin
            // only the line's own in-service bit masks it
            cand = pending_model & ~service_model & piae_pkg::ACTIVE_MASK;
            for (int i = 0; i < piae_pkg::LINE_SLOTS; i++) begin
               if (cand[i] && hit < 0) hit = i;
            end
            // no candidate means a spurious acknowledge, state stays as it is
            if (hit >= 0) begin
               pending_model[piae_pkg::LINE_W'(hit)] = 1'b0;
               service_model[piae_pkg::LINE_W'(hit)] = 1'b1;
               word.vector        = vector_table[piae_pkg::LINE_W'(hit)];
               word.vector_valid  = 1'b1;
               word.served_line   = piae_pkg::LINE_W'(hit);
            end
         end
         default: begin
            // end of interrupt clears the lowest in-service line, if any
            for (int i = 0; i < piae_pkg::LINE_SLOTS; i++) begin
               if (service_model[i] && hit < 0) hit = i;
            end
            if (hit >= 0) begin
               service_model[piae_pkg::LINE_W'(hit)] = 1'b0;
               word.eoi_done      = 1'b1;
               word.served_line   = piae_pkg::LINE_W'(hit);
            end
         end
      endcase
      word.pending_now    = pending_model;
      word.in_service_now = service_model;
      return word;
   endfunction

   // ---------------------------------------------------------------------
   // shared bench state
   // ---------------------------------------------------------------------
   irq_request_type        request_backlog [$];   // words waiting for the sender
   piae_pkg::rsp_word_type awaited_status  [$];   // status words the block still owes
   int                     queued_total = 0;
   int                     fault_count  = 0;
   bit                     req_fired    = 1'b0;   // request word taken at the last rising edge
   bit                     calm         = 1'b0;   // no idling on either side
   bit                     hold_request = 1'b0;   // ask the receiver for a long hold-off
   int                     hold_left    = 0;
   int                     send_gap     = 0;
   int                     recv_gap     = 0;
   bit                     stall_next;
   irq_request_type        next_request;
   piae_pkg::rsp_word_type want;

   // ---------------------------------------------------------------------
   // sender: offers queued words, holds a word steady until it is taken
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            // start an idle burst, this cycle counts as its first
            send_gap = $urandom_range(1, BURST_MAX) - 1;
            req_valid <= 1'b0;
         end else if (request_backlog.size() > 0) begin
            next_request = request_backlog.pop_front();
            req_valid <= 1'b1;
            req_type  <= next_request.kind;
            req_line  <= next_request.line;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver: random stall bursts plus an occasional long hold-off
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (reset) begin
         stall_next = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         stall_next = 1'b1;
      end else if (recv_gap > 0) begin
         recv_gap--;
         stall_next = 1'b1;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
         recv_gap   = $urandom_range(1, BURST_MAX) - 1;
         stall_next = 1'b1;
      end else begin
         stall_next = 1'b0;
      end
      rsp_stall <= stall_next;
   end

   // ---------------------------------------------------------------------
   // monitor: check taken status words, then predict for taken requests
   // ---------------------------------------------------------------------
   task automatic check_field(string name, logic [7:0] expected, logic [7:0] actual);
      if (actual !== expected) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, expected, actual);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_fired = 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (awaited_status.size() == 0) begin
               $error("status word with nothing outstanding");
               fault_count++;
            end else begin
               want = awaited_status.pop_front();
               check_field("vector",         want.vector,             rsp_vector);
               check_field("vector_valid",   8'(want.vector_valid),   8'(rsp_vector_valid));
               check_field("served_line",    8'(want.served_line),    8'(rsp_served_line));
               check_field("eoi_done",       8'(want.eoi_done),       8'(rsp_eoi_done));
               check_field("pending_now",    want.pending_now,        rsp_pending_now);
               check_field("in_service_now", want.in_service_now,     rsp_in_service_now);
            end
         end
         req_fired = req_valid && (req_stall === 1'b0);
         if (req_fired) begin
            awaited_status.push_back(
               resolve_request(piae_pkg::req_code_type'(req_type), req_line));
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_request(piae_pkg::req_code_type kind,
                               logic [piae_pkg::LINE_W-1:0] ln);
      irq_request_type item;
      item.kind = kind;
      item.line = ln;
      request_backlog.push_back(item);
      queued_total++;
   endtask

   function automatic logic [piae_pkg::LINE_W-1:0] any_line();
      return piae_pkg::LINE_W'($urandom_range(0, piae_pkg::LINE_SLOTS - 1));
   endfunction

   // wait until every queued word is sent and answered, bounded
   task automatic drain();
      int waited;
      waited = 0;
      while ((request_backlog.size() > 0 || req_valid || awaited_status.size() > 0)
             && waited < DRAIN_CYCLES) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE) @(negedge clock);
      if (awaited_status.size() > 0) begin
         $error("%0d status words never arrived", awaited_status.size());
         fault_count++;
         awaited_status.delete();
      end
   endtask

   // write every index the port reaches; the ones past the list must be dropped
   task automatic program_vectors(vec_style_type style);
      logic [piae_pkg::CSR_DATA_W-1:0] data;
      for (int idx = 0; idx < (1 << piae_pkg::CSR_IDX_W); idx++) begin
         case (style)
            VEC_ALL_ZERO:  data = '0;
            VEC_ALL_ONES:  data = '1;
            VEC_ALTERNATE: data = idx[0] ? '1 : '0;
            default:       data = piae_pkg::CSR_DATA_W'($urandom);
         endcase
         if (idx >= piae_pkg::CFG_COUNT) data = piae_pkg::CSR_DATA_W'($urandom);
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= piae_pkg::CSR_IDX_W'(idx);
         csr_wdata <= data;
         if (idx < piae_pkg::CFG_COUNT) vector_table[piae_pkg::LINE_W'(idx)] = data;
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly well-formed raise / acknowledge / end runs, the rest single noise words
   task automatic queue_random_requests(int count);
      int start, k;
      start = queued_total;
      while (queued_total - start < count) begin
         if ($urandom_range(0, 9) < 6) begin
            k = $urandom_range(1, piae_pkg::LINE_SLOTS);
            repeat (k) push_request(piae_pkg::REQ_RAISE, any_line());
            if ($urandom_range(0, 3) == 0) push_request(piae_pkg::REQ_WITHDRAW, any_line());
            repeat (k + $urandom_range(0, 1)) begin
               push_request($urandom_range(0, 3) == 0 ? piae_pkg::REQ_RAISE
                                                      : piae_pkg::REQ_ACK, any_line());
            end
            repeat (k + $urandom_range(0, 1)) begin
               push_request($urandom_range(0, 4) == 0 ? piae_pkg::REQ_ACK
                                                      : piae_pkg::REQ_EOI, any_line());
            end
         end else begin
            push_request(piae_pkg::req_code_type'($urandom_range(0, 3)), any_line());
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      for (int i = 0; i < piae_pkg::CFG_COUNT; i++) vector_table[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset vectors: spurious acknowledge and end with nothing in service, then a raise and an acknowledge
      push_request(piae_pkg::REQ_ACK, 3'd7);
      push_request(piae_pkg::REQ_EOI, 3'd5);
      push_request(piae_pkg::REQ_RAISE, 3'd4);
      push_request(piae_pkg::REQ_ACK, 3'd0);
      drain();

      program_vectors(VEC_ALTERNATE);
      // priority order, own in-service masking, re-raise, withdraw, ignored line field
      push_request(piae_pkg::REQ_RAISE, 3'd7);
      push_request(piae_pkg::REQ_RAISE, 3'd0);
      push_request(piae_pkg::REQ_RAISE, 3'd0);
      push_request(piae_pkg::REQ_RAISE, 3'd3);
      push_request(piae_pkg::REQ_ACK, 3'd7);
      push_request(piae_pkg::REQ_RAISE, 3'd0);
      push_request(piae_pkg::REQ_ACK, 3'd0);
      push_request(piae_pkg::REQ_ACK, 3'd5);
      push_request(piae_pkg::REQ_ACK, 3'd2);
      push_request(piae_pkg::REQ_EOI, 3'd7);
      push_request(piae_pkg::REQ_ACK, 3'd1);
      push_request(piae_pkg::REQ_WITHDRAW, 3'd7);
      push_request(piae_pkg::REQ_RAISE, 3'd5);
      push_request(piae_pkg::REQ_WITHDRAW, 3'd5);
      push_request(piae_pkg::REQ_EOI, 3'd0);
      push_request(piae_pkg::REQ_EOI, 3'd6);
      push_request(piae_pkg::REQ_EOI, 3'd1);
      push_request(piae_pkg::REQ_EOI, 3'd2);
      push_request(piae_pkg::REQ_EOI, 3'd3);
      drain();

      program_vectors(VEC_ALL_ONES);
      queue_random_requests(265);
      drain();

      // long receiver hold-off while the sender keeps offering words
      program_vectors(VEC_RANDOM);
      hold_request = 1'b1;
      queue_random_requests(265);
      drain();

      program_vectors(VEC_ALL_ZERO);
      queue_random_requests(265);
      drain();

      program_vectors(VEC_RANDOM);
      queue_random_requests(265);
      drain();

      // last stretch runs back to back on both sides
      program_vectors(VEC_RANDOM);
      calm = 1'b1;
      queue_random_requests(265);
      drain();

      if (fault_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #3000000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
